// ===== design/tcw_pkg.sv =====
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int OPCODE_W    = 2;
  localparam int GLYPH_W     = 8;
  localparam int ATTR_W      = 8;
  localparam int CELL_W      = GLYPH_W + ATTR_W;
  localparam int QROW_W      = 5;
  localparam int QCOL_W      = 7;
  localparam int CUR_ROW_W   = 5;
  localparam int CUR_COL_W   = 7;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [GLYPH_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [GLYPH_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [GLYPH_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [ATTR_W-1:0]  RESET_COLOR  = 8'h07;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SPARE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [GLYPH_W-1:0] glyph;
    logic [QROW_W-1:0]  row;
    logic [QCOL_W-1:0]  col;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_READ,
    S_RESP
  } back_state_t;

endpackage

// ===== design/tcw_if.sv =====
interface tcw_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_code;
  logic [4:0] cell_row;
  logic [6:0] cell_col;

  modport source (output valid, output opcode, output char_code, output cell_row,
                  output cell_col, input ready);
  modport sink (input valid, input opcode, input char_code, input cell_row,
                input cell_col, output ready);
endinterface

interface tcw_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_glyph;
  logic [7:0] cell_attr;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;

  modport source (output valid, output cell_glyph, output cell_attr, output cursor_row,
                  output cursor_col, input ready);
  modport sink (input valid, input cell_glyph, input cell_attr, input cursor_row,
                input cursor_col, output ready);
endinterface

// ===== design/tcw_front.sv =====
module tcw_front (
  tcw_cmd_if.sink       cmd,
  input  logic          init_busy,
  output logic          push_valid,
  input  logic          push_ready,
  output tcw_pkg::cmd_t push_cmd
);
  import tcw_pkg::*;

  cmd_kind_t kind;

  always_comb begin
    unique case (opcode_t'(cmd.opcode))
      OP_PUT: begin
        priority if (cmd.char_code == CH_NEWLINE) kind = CMD_NEWLINE;
        else if (cmd.char_code == CH_BACKSPACE) kind = CMD_BACKSPACE;
        else kind = CMD_PUT;
      end
      OP_CLEAR: kind = CMD_CLEAR;
      OP_READ, OP_SPARE: kind = CMD_READ;
      default: kind = CMD_READ;
    endcase
  end

  // no items taken while the screen is swept after reset
  assign cmd.ready  = push_ready && !init_busy;
  assign push_valid = cmd.valid && !init_busy;

  assign push_cmd.kind  = kind;
  assign push_cmd.glyph = cmd.char_code;
  assign push_cmd.row   = cmd.cell_row;
  assign push_cmd.col   = cmd.cell_col;

endmodule

// ===== design/tcw_queue.sv =====
module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          head_valid,
  input  logic          pop,
  output tcw_pkg::cmd_t head
);
  import tcw_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          push;
  logic          pull;

  assign push_ready = count != NW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pull       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pull) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pull) begin
        count <= count + 1'b1;
      end else if (pull && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== design/tcw_back.sv =====
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        text_color_we,
  input  logic [tcw_pkg::ATTR_W-1:0]  text_color_wdata,
  input  logic                        head_valid,
  input  tcw_pkg::cmd_t               head,
  output logic                        pop,
  output logic                        init_busy,
  tcw_rsp_if.source                   rsp
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  logic [CELL_W-1:0] screen [CELLS];

  back_state_t       state;
  back_state_t       state_next;
  logic [RW-1:0]     cur_row;
  logic [CW-1:0]     cur_col;
  logic [AW-1:0]     top_base;
  logic [ATTR_W-1:0] text_color;
  logic [AW-1:0]     fill_addr;
  logic [AW-1:0]     fill_last;
  logic [CELL_W-1:0] fill_cell;
  logic              fill_init;
  logic [QROW_W-1:0] q_row;
  logic [QCOL_W-1:0] q_col;
  logic              q_hit;
  logic              byp;
  logic [CELL_W-1:0] byp_data;
  logic [CELL_W-1:0] rd_data;

  logic                 rsp_valid;
  logic [GLYPH_W-1:0]   rsp_glyph;
  logic [ATTR_W-1:0]    rsp_attr;
  logic [CUR_ROW_W-1:0] rsp_row;
  logic [CUR_COL_W-1:0] rsp_col;
  logic                 out_free;

  logic              exec;
  logic              do_put;
  logic              do_nl;
  logic              do_bs;
  logic              do_clr;
  logic              advance;
  logic              scroll;
  logic [CW:0]       col_inc;
  logic              wrap;
  logic              row_last;
  logic              ex_we;
  logic [CW-1:0]     ex_col;
  logic [CELL_W-1:0] ex_data;
  logic [AW-1:0]     wr_row_off;
  logic [AW:0]       wr_sum;
  logic [AW-1:0]     ex_addr;
  logic              rd_en;
  logic [QROW_W-1:0] rd_row;
  logic [QCOL_W-1:0] rd_col;
  logic [AW-1:0]     rd_row_off;
  logic [AW:0]       rd_sum;
  logic [AW-1:0]     rd_addr;
  logic              head_hit;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW:0]       top_add;
  logic [AW-1:0]     top_next;
  logic [CELL_W-1:0] blank;
  logic [CELL_W-1:0] rd_cell;
  logic              fill_done;

  assign out_free  = !rsp_valid || rsp.ready;
  assign exec      = (state == S_IDLE) && head_valid;
  assign pop       = exec;
  assign init_busy = fill_init;
  assign fill_done = fill_addr == fill_last;
  assign blank     = {text_color, CH_SPACE};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (head_valid) begin
          state_next = (do_clr || scroll) ? S_FILL : S_RESP;
        end
      end
      S_FILL: begin
        if (fill_done) begin
          state_next = fill_init ? S_IDLE : S_READ;
        end
      end
      S_READ: state_next = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // command decode and cursor arithmetic
  always_comb begin
    do_put   = exec && (head.kind == CMD_PUT);
    do_nl    = exec && (head.kind == CMD_NEWLINE);
    do_bs    = exec && (head.kind == CMD_BACKSPACE) && (cur_col != '0);
    do_clr   = exec && (head.kind == CMD_CLEAR);
    col_inc  = {1'b0, cur_col} + 1'b1;
    wrap     = col_inc == (CW + 1)'(COLUMNS);
    row_last = cur_row == RW'(ROWS - 1);
    advance  = (do_put && wrap) || do_nl;
    scroll   = advance && row_last;
    ex_we    = do_put || do_bs;
    ex_col   = do_bs ? cur_col - 1'b1 : cur_col;
    ex_data  = {text_color, do_bs ? CH_SPACE : head.glyph};
  end

  // physical addresses: rows are kept as a ring starting at top_base
  always_comb begin
    wr_row_off = AW'(cur_row) * AW'(COLUMNS);
    wr_sum     = {1'b0, top_base} + {1'b0, wr_row_off} + (AW + 1)'(ex_col);
    ex_addr    = (wr_sum >= (AW + 1)'(CELLS)) ? AW'(wr_sum - (AW + 1)'(CELLS))
                                              : wr_sum[AW-1:0];
    rd_row     = (state == S_READ) ? q_row : head.row;
    rd_col     = (state == S_READ) ? q_col : head.col;
    rd_row_off = AW'(rd_row) * AW'(COLUMNS);
    rd_sum     = {1'b0, top_base} + {1'b0, rd_row_off} + (AW + 1)'(rd_col);
    rd_addr    = (rd_sum >= (AW + 1)'(CELLS)) ? AW'(rd_sum - (AW + 1)'(CELLS))
                                              : rd_sum[AW-1:0];
    rd_en      = (exec && !scroll && !do_clr) || (state == S_READ);
    head_hit   = (32'(head.row) < 32'(ROWS)) && (32'(head.col) < 32'(COLUMNS));
    top_add    = {1'b0, top_base} + (AW + 1)'(COLUMNS);
    top_next   = (top_add == (AW + 1)'(CELLS)) ? '0 : top_add[AW-1:0];
    mem_we     = (state == S_FILL) || ex_we;
    mem_waddr  = (state == S_FILL) ? fill_addr : ex_addr;
    mem_wdata  = (state == S_FILL) ? fill_cell : ex_data;
    rd_cell    = byp ? byp_data : rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      fill_init  <= 1'b1;
      fill_addr  <= '0;
      fill_last  <= AW'(CELLS - 1);
      fill_cell  <= {RESET_COLOR, CH_SPACE};
      cur_row    <= '0;
      cur_col    <= '0;
      top_base   <= '0;
      text_color <= RESET_COLOR;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (text_color_we) begin
        text_color <= text_color_wdata;
      end
      if (state == S_FILL) begin
        fill_addr <= fill_addr + 1'b1;
        if (fill_done) begin
          fill_init <= 1'b0;
        end
      end
      if (do_put) begin
        if (wrap) begin
          cur_col <= '0;
          if (!row_last) begin
            cur_row <= cur_row + 1'b1;
          end
        end else begin
          cur_col <= col_inc[CW-1:0];
        end
      end
      if (do_nl) begin
        cur_col <= '0;
        if (!row_last) begin
          cur_row <= cur_row + 1'b1;
        end
      end
      if (do_bs) begin
        cur_col <= ex_col;
      end
      if (do_clr) begin
        cur_row   <= '0;
        cur_col   <= '0;
        top_base  <= '0;
        fill_addr <= '0;
        fill_last <= AW'(CELLS - 1);
        fill_cell <= blank;
      end
      // scroll: the old top row becomes the new bottom row and is blanked
      if (scroll) begin
        top_base  <= top_next;
        fill_addr <= top_base;
        fill_last <= top_base + AW'(COLUMNS - 1);
        fill_cell <= blank;
      end
      if (state == S_RESP && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= screen[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      q_row    <= head.row;
      q_col    <= head.col;
      q_hit    <= head_hit;
      // read and write of the same cell in one cycle
      byp      <= ex_we && (ex_addr == rd_addr);
      byp_data <= ex_data;
    end else if (state == S_READ) begin
      byp <= 1'b0;
    end
    if (state == S_RESP && out_free) begin
      rsp_glyph <= q_hit ? rd_cell[GLYPH_W-1:0] : '0;
      rsp_attr  <= q_hit ? rd_cell[CELL_W-1:GLYPH_W] : '0;
      rsp_row   <= CUR_ROW_W'(cur_row);
      rsp_col   <= CUR_COL_W'(cur_col);
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.cell_glyph = rsp_glyph;
  assign rsp.cell_attr  = rsp_attr;
  assign rsp.cursor_row = rsp_row;
  assign rsp.cursor_col = rsp_col;

endmodule

// ===== design/text_console_writer.sv =====
// channel     dir  payload                                       accepted when
// cmd         in   opcode, char_code, cell_row, cell_col         valid && ready
// rsp         out  cell_glyph, cell_attr, cursor_row, cursor_col valid && ready
// text_color  in   text_color_wdata                              text_color_we
//
// after reset a sweep writes all ROWS*COLUMNS cells (2000 by default) blank;
// cmd.ready is low until it ends
// put, backspace, newline and read go through the sequencer as a write plus
// cell read, then the result register load, which waits on a stalled rsp
// a scroll adds a blanking pass over the new bottom row, a clear one over all
// cells, then a cell read; the single write port of the screen memory sets both
// a two-entry queue keeps cmd open while the sequencer waits on a stalled rsp
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       text_color_we,
  input  logic [tcw_pkg::ATTR_W-1:0] text_color_wdata,
  tcw_cmd_if.sink                    cmd,
  tcw_rsp_if.source                  rsp
);
  import tcw_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic head_valid;
  cmd_t head;
  logic pop;
  logic init_busy;

  tcw_front u_front (
    .cmd        (cmd),
    .init_busy  (init_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .text_color_we    (text_color_we),
    .text_color_wdata (text_color_wdata),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .init_busy        (init_busy),
    .rsp              (rsp)
  );

endmodule

// ===== design/tcw_checker.sv =====
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_cell_glyph,
  input logic [7:0] rsp_cell_attr,
  input logic [4:0] rsp_cursor_row,
  input logic [6:0] rsp_cursor_col
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      $stable({rsp_cell_glyph, rsp_cell_attr, rsp_cursor_row, rsp_cursor_col}))
    else $error("rsp payload changed while stalled");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((ROWS > 32) || (32'(rsp_cursor_row) < 32'(ROWS))) &&
                  ((COLUMNS > 128) || (32'(rsp_cursor_col) < 32'(COLUMNS))))
    else $error("cursor reported off screen");

  a_sweep_blocks: assert property (@(posedge clk)
    $past(rst) |-> !cmd_ready)
    else $error("cmd accepted during reset sweep");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_cell_glyph (rsp.cell_glyph),
  .rsp_cell_attr  (rsp.cell_attr),
  .rsp_cursor_row (rsp.cursor_row),
  .rsp_cursor_col (rsp.cursor_col)
);

// ===== tb/sv/text_console_writer_tb.sv =====
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int SCR_COLS = COLUMNS_DEF;
  localparam int SCR_ROWS = ROWS_DEF;
  localparam int CELLS = SCR_COLS * SCR_ROWS;
  localparam int LIMIT = 500000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int NUM_DIR = 20;
  localparam int NUM_PHASES = 4;

  typedef struct packed {
    opcode_t            op;
    logic [GLYPH_W-1:0] ch;
    logic [QROW_W-1:0]  row;
    logic [QCOL_W-1:0]  col;
  } cmd_item_t;

  typedef struct packed {
    logic [GLYPH_W-1:0]   glyph;
    logic [ATTR_W-1:0]    attr;
    logic [CUR_ROW_W-1:0] crow;
    logic [CUR_COL_W-1:0] ccol;
  } cell_report_t;

  typedef struct packed {
    cmd_item_t    item;
    logic         fixed;
    cell_report_t want;
  } dir_row_t;

  // fixed rows carry a typed-in result, the others go through the predictor
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{'{OP_READ,  8'h00, 5'd0,  7'd0},   1'b1, '{8'h20, 8'h07, 5'd0, 7'd0}},
    '{'{OP_READ,  8'h00, 5'd24, 7'd79},  1'b1, '{8'h20, 8'h07, 5'd0, 7'd0}},
    '{'{OP_READ,  8'h00, 5'd25, 7'd0},   1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{'{OP_READ,  8'h00, 5'd0,  7'd80},  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{'{OP_SPARE, 8'hFF, 5'd31, 7'd127}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{'{OP_PUT,   8'h08, 5'd0,  7'd0},   1'b1, '{8'h20, 8'h07, 5'd0, 7'd0}},
    '{'{OP_PUT,   8'h41, 5'd0,  7'd0},   1'b1, '{8'h41, 8'h07, 5'd0, 7'd1}},
    '{'{OP_PUT,   8'hFF, 5'd0,  7'd1},   1'b1, '{8'hFF, 8'h07, 5'd0, 7'd2}},
    '{'{OP_PUT,   8'h00, 5'd0,  7'd2},   1'b1, '{8'h00, 8'h07, 5'd0, 7'd3}},
    '{'{OP_PUT,   8'h08, 5'd0,  7'd2},   1'b1, '{8'h20, 8'h07, 5'd0, 7'd2}},
    '{'{OP_PUT,   8'h0A, 5'd0,  7'd0},   1'b1, '{8'h41, 8'h07, 5'd1, 7'd0}},
    '{'{OP_PUT,   8'h5A, 5'd1,  7'd0},   1'b1, '{8'h5A, 8'h07, 5'd1, 7'd1}},
    '{'{OP_PUT,   8'h80, 5'd1,  7'd1},   1'b0, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{'{OP_PUT,   8'h7F, 5'd31, 7'd127}, 1'b0, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{'{OP_READ,  8'hAA, 5'd1,  7'd2},   1'b0, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{'{OP_SPARE, 8'h55, 5'd1,  7'd0},   1'b0, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{'{OP_CLEAR, 8'h00, 5'd0,  7'd0},   1'b1, '{8'h20, 8'h07, 5'd0, 7'd0}},
    '{'{OP_READ,  8'hFF, 5'd1,  7'd0},   1'b1, '{8'h20, 8'h07, 5'd0, 7'd0}},
    '{'{OP_PUT,   8'h20, 5'd0,  7'd0},   1'b0, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{'{OP_PUT,   8'h0A, 5'd24, 7'd79},  1'b0, '{8'h00, 8'h00, 5'd0, 7'd0}}
  };

  // per phase: newline, backspace and clear weights in percent, item count
  localparam int PH_NL    [NUM_PHASES] = '{30, 0, 10, 5};
  localparam int PH_BS    [NUM_PHASES] = '{10, 3, 15, 5};
  localparam int PH_CLR   [NUM_PHASES] = '{2, 0, 3, 2};
  localparam int PH_ITEMS [NUM_PHASES] = '{100, 110, 90, 100};

  logic                clk;
  logic                rst;
  logic                text_color_we;
  logic [ATTR_W-1:0]   text_color_wdata;

  tcw_cmd_if cmd_ch ();
  tcw_rsp_if rsp_ch ();

  text_console_writer dut (
    .clk              (clk),
    .rst              (rst),
    .text_color_we    (text_color_we),
    .text_color_wdata (text_color_wdata),
    .cmd              (cmd_ch),
    .rsp              (rsp_ch)
  );

  // predicted console state
  logic [CELL_W-1:0] screen [CELLS];
  int                cur_r;
  int                cur_c;
  logic [ATTR_W-1:0] color;

  cell_report_t pending_reports [$];
  int           errors = 0;
  int           cycles = 0;
  bit           hold_off_req;
  bit           idle_off;

  function automatic logic [CELL_W-1:0] blank_cell();
    return {color, CH_SPACE};
  endfunction

  function automatic void next_row();
    cur_c = 0;
    cur_r++;
    if (cur_r >= SCR_ROWS) begin
      for (int i = 0; i < CELLS - SCR_COLS; i++) screen[i] = screen[i + SCR_COLS];
      for (int i = CELLS - SCR_COLS; i < CELLS; i++) screen[i] = blank_cell();
      cur_r = SCR_ROWS - 1;
    end
  endfunction

  function automatic cell_report_t console_step(cmd_item_t it);
    cell_report_t r;
    logic [CELL_W-1:0] c;
    c = '0;
    if (it.op == OP_PUT) begin
      if (it.ch == CH_NEWLINE) begin
        next_row();
      end else if (it.ch == CH_BACKSPACE) begin
        if (cur_c > 0) begin
          cur_c--;
          screen[cur_r * SCR_COLS + cur_c] = blank_cell();
        end
      end else begin
        screen[cur_r * SCR_COLS + cur_c] = {color, it.ch};
        cur_c++;
        if (cur_c >= SCR_COLS) next_row();
      end
    end else if (it.op == OP_CLEAR) begin
      for (int i = 0; i < CELLS; i++) screen[i] = blank_cell();
      cur_r = 0;
      cur_c = 0;
    end
    if (int'(it.row) < SCR_ROWS && int'(it.col) < SCR_COLS)
      c = screen[int'(it.row) * SCR_COLS + int'(it.col)];
    r.glyph = c[GLYPH_W-1:0];
    r.attr  = c[CELL_W-1:GLYPH_W];
    r.crow  = cur_r[CUR_ROW_W-1:0];
    r.ccol  = cur_c[CUR_COL_W-1:0];
    return r;
  endfunction

  function automatic cmd_item_t random_item(int nl_pct, int bs_pct, int clr_pct);
    cmd_item_t it;
    int r;
    int q;
    r = $urandom_range(0, 99);
    it.ch = GLYPH_W'($urandom_range(0, 255));
    if (r < clr_pct) begin
      it.op = OP_CLEAR;
    end else if (r < clr_pct + 12) begin
      it.op = OP_READ;
    end else if (r < clr_pct + 15) begin
      it.op = OP_SPARE;
    end else begin
      it.op = OP_PUT;
      q = $urandom_range(0, 99);
      if (q < nl_pct) it.ch = CH_NEWLINE;
      else if (q < nl_pct + bs_pct) it.ch = CH_BACKSPACE;
    end
    // mostly cells on screen, many on the cursor row, a few anywhere
    q = $urandom_range(0, 9);
    if (q == 0) begin
      it.row = QROW_W'($urandom_range(0, 31));
      it.col = QCOL_W'($urandom_range(0, 127));
    end else if (q < 5) begin
      it.row = cur_r[QROW_W-1:0];
      it.col = QCOL_W'($urandom_range(0, SCR_COLS - 1));
    end else begin
      it.row = QROW_W'($urandom_range(0, SCR_ROWS - 1));
      it.col = QCOL_W'($urandom_range(0, SCR_COLS - 1));
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (errors < 40)
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(cmd_item_t it, logic fixed, cell_report_t want);
    int gap;
    cell_report_t predicted;
    gap = idle_off ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.opcode    <= it.op;
    cmd_ch.char_code <= it.ch;
    cmd_ch.cell_row  <= it.row;
    cmd_ch.cell_col  <= it.col;
    do @(posedge clk); while (!cmd_ch.ready);
    predicted = console_step(it);
    pending_reports.push_back(fixed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic set_color(logic [ATTR_W-1:0] v);
    cmd_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    text_color_we    <= 1'b1;
    text_color_wdata <= v;
    @(negedge clk);
    text_color_we <= 1'b0;
    color = v;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("text_console_writer test failed");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    cell_report_t got;
    cell_report_t want;
    if (rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.cell_glyph, rsp_ch.cell_attr, rsp_ch.cursor_row, rsp_ch.cursor_col};
      if (pending_reports.size() == 0) begin
        report_mismatch("item with nothing pending", int'(got), 0);
      end else begin
        want = pending_reports.pop_front();
        if (got.glyph !== want.glyph)
          report_mismatch("cell_glyph", int'(got.glyph), int'(want.glyph));
        if (got.attr !== want.attr)
          report_mismatch("cell_attr", int'(got.attr), int'(want.attr));
        if (got.crow !== want.crow)
          report_mismatch("cursor_row", int'(got.crow), int'(want.crow));
        if (got.ccol !== want.ccol)
          report_mismatch("cursor_col", int'(got.ccol), int'(want.ccol));
      end
    end
  end

  // result receiver
  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      gap = idle_off ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    logic [ATTR_W-1:0] ph_color [NUM_PHASES];
    rst              = 1'b1;
    text_color_we    = 1'b0;
    text_color_wdata = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.opcode    = OP_PUT;
    cmd_ch.char_code = '0;
    cmd_ch.cell_row  = '0;
    cmd_ch.cell_col  = '0;
    hold_off_req     = 1'b0;
    idle_off         = 1'b0;
    color            = RESET_COLOR;
    cur_r            = 0;
    cur_c            = 0;
    for (int i = 0; i < CELLS; i++) screen[i] = {RESET_COLOR, CH_SPACE};
    ph_color[0] = 8'h00;
    ph_color[1] = 8'hFF;
    ph_color[2] = ATTR_W'($urandom_range(0, 255));
    ph_color[3] = ATTR_W'($urandom_range(0, 255));

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < NUM_DIR; i++)
      send_item(DIR_ROWS[i].item, DIR_ROWS[i].fixed, DIR_ROWS[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_color(ph_color[p]);
      for (int i = 0; i < PH_ITEMS[p]; i++) begin
        // the phase with no newlines or clears also hosts the long receiver stall
        if (p == 1 && i == 40) hold_off_req = 1'b1;
        idle_off = (p == 3 && i < 50);
        send_item(random_item(PH_NL[p], PH_BS[p], PH_CLR[p]), 1'b0, '0);
      end
    end
    idle_off = 1'b0;

    cmd_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("text_console_writer test passed");
    end else begin
      $display("text_console_writer test failed");
    end
    $finish;
  end

endmodule
